// File: hdl/ocwt_pkg.sv
package ocwt_pkg;

  // Table geometry. TABLE_SIZE is a power of two; the phase top bits index it.
  localparam int TABLE_SIZE  = 2048;
  localparam int TABLE_COUNT = 11;
  localparam int IDX_W       = $clog2(TABLE_SIZE);

  // Even tables 0,2,..,10 live in one bank, odd tables 1,3,..,9 in the other.
  localparam int SLOT_W          = 3;
  localparam int EVEN_DEPTH      = ((TABLE_COUNT + 1) / 2) * TABLE_SIZE;
  localparam int ODD_DEPTH       = (TABLE_COUNT / 2) * TABLE_SIZE;
  localparam int MEM_AW          = SLOT_W + IDX_W;
  localparam logic [SLOT_W-1:0] TOP_EVEN_SLOT = SLOT_W'((TABLE_COUNT - 1) / 2);

  // Field and register widths.
  localparam int SEL_W   = 4;
  localparam int TIDX_W  = 11;
  localparam int WORD_W  = 16;
  localparam int FREQ_W  = 20;
  localparam int PHASE_W = 32;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FREQUENCY  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 1'd1;

  // Frequency edges in Q16.4 Hz.
  localparam logic [FREQ_W-1:0] FREQ_LOW_EDGE = 20'd320;
  localparam logic [FREQ_W-1:0] FREQ_TOP_EDGE = 20'd327680;
  localparam logic [FREQ_W-1:0] FREQ_CUTOFF   = 20'd384000;
  localparam int OCT_W   = 4;
  localparam int OCT_MAX = TABLE_COUNT - 2;

  // Weight = floor(d * 2^16 / (320 * 2^k)) = floor(((d << 10) >> k) / 5).
  localparam int W_W         = 16;
  localparam int Y_W         = 19;
  localparam int PRE_SHIFT   = 10;
  localparam int DIV5_SHIFT  = 21;
  localparam logic [Y_W-1:0] DIV5_MUL = 19'd419431;

endpackage

// File: hdl/ocwt_in_if.sv
interface ocwt_in_if import ocwt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [SEL_W-1:0]         table_select;
  logic [TIDX_W-1:0]        table_index;
  logic signed [WORD_W-1:0] table_word;

  modport source(output valid, mode, table_select, table_index, table_word, input ready);
  modport sink(input valid, mode, table_select, table_index, table_word, output ready);
endinterface

// File: hdl/ocwt_out_if.sv
interface ocwt_out_if import ocwt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] sample_out;

  modport source(output valid, sample_out, input ready);
  modport sink(input valid, sample_out, output ready);
endinterface

// File: hdl/octave_crossfade_wavetable_osc.sv
// Octave-crossfade wavetable oscillator. A load word (mode 1) writes one table entry
// and gives no result; a tick word (mode 0) advances the 32-bit phase by phase_step
// and returns one crossfaded sample. The block takes one word per cycle while the
// output is not stalled and no reset or frequency write holds the input off.
// The table read is registered when a tick is accepted, then the crossfade product,
// then the rounded sample offered on out_ch; a stalled output holds the stages
// behind it. The tables sit in two single-port banks (even and odd octaves), so both
// neighboring octaves are read in the same cycle. The tables are not cleared at reset;
// every entry must be loaded before a tick reads it. A phase_step write takes effect
// for the word accepted in the next cycle. After reset and after a frequency write the
// input is held off while the two-stage octave weight path catches up.
module octave_crossfade_wavetable_osc import ocwt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  ocwt_in_if.sink              in_ch,
  ocwt_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  typedef enum logic [1:0] {BAND_LOW, BAND_MIX, BAND_TOP, BAND_OFF} band_kind_t;

  logic [FREQ_W-1:0]  freq_r;
  logic [PHASE_W-1:0] step_r;
  logic [PHASE_W-1:0] acc_r;
  logic [PHASE_W-1:0] acc_nxt;
  logic               freq_hold_r;

  logic signed [WORD_W-1:0] even_mem [EVEN_DEPTH];
  logic signed [WORD_W-1:0] odd_mem  [ODD_DEPTH];
  logic signed [WORD_W-1:0] even_rd_r;
  logic signed [WORD_W-1:0] odd_rd_r;

  band_kind_t         band_kind;
  logic [OCT_W-1:0]   band_k;
  logic [FREQ_W-1:0]  hi_edge;
  logic [FREQ_W-1:0]  hi_gap;
  logic [FREQ_W+PRE_SHIFT-1:0] hi_gap_sh;
  logic [Y_W-1:0]     y_r;
  logic [2*Y_W-1:0]   wq;
  logic [W_W-1:0]     w_r;

  logic               in_acc;
  logic               tick_acc;
  logic               load_ok;
  logic [MEM_AW-1:0]  wr_addr;
  logic [MEM_AW-1:0]  even_rd_addr;
  logic [MEM_AW-1:0]  odd_rd_addr;
  logic [SLOT_W-1:0]  even_slot;
  logic [IDX_W-1:0]   rd_idx;

  logic               s1_v_r;
  band_kind_t         s1_kind_r;
  logic               s1_swap_r;
  logic               s2_v_r;
  logic signed [2*WORD_W+1:0] prod_r;
  logic signed [2*WORD_W+1:0] prod_nxt;
  logic signed [WORD_W-1:0]   b_r;
  logic signed [WORD_W-1:0]   b_nxt;
  logic signed [WORD_W:0]     diff;
  logic signed [W_W:0]        w_sgn;
  logic signed [2*WORD_W+2:0] mix;
  logic signed [WORD_W+2:0]   rnd;
  logic signed [WORD_W-1:0]   sat;
  logic                       out_v_r;
  logic signed [WORD_W-1:0]   out_r;
  logic               adv1;
  logic               adv2;
  logic               adv3;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r <= '0;
      step_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FREQUENCY:  freq_r <= cfg_data[FREQ_W-1:0];
        CFG_PHASE_STEP: step_r <= cfg_data[PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  // The weight trails freq_r by two registers, so a new frequency keeps the input
  // closed while the weight catches up.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_hold_r <= 1'b1;
    end else begin
      freq_hold_r <= cfg_we && (cfg_index == CFG_FREQUENCY);
    end
  end

  // Octave band from the configured frequency.
  always_comb begin
    band_k = '0;
    for (int j = 1; j <= OCT_MAX; j++) begin
      if (freq_r > (FREQ_LOW_EDGE << j)) begin
        band_k = OCT_W'(j);
      end
    end
    if (freq_r <= FREQ_LOW_EDGE) begin
      band_kind = BAND_LOW;
    end else if (freq_r <= FREQ_TOP_EDGE) begin
      band_kind = BAND_MIX;
    end else if (freq_r <= FREQ_CUTOFF) begin
      band_kind = BAND_TOP;
    end else begin
      band_kind = BAND_OFF;
    end
    hi_edge   = FREQ_LOW_EDGE << (band_k + OCT_W'(1));
    hi_gap    = hi_edge - freq_r;
    hi_gap_sh = {hi_gap, PRE_SHIFT'(0)} >> band_k;
  end

  // Weight pipeline: the divide by 5 is a reciprocal multiply.
  assign wq = (2*Y_W)'(y_r) * (2*Y_W)'(DIV5_MUL);

  always_ff @(posedge clk) begin
    y_r <= hi_gap_sh[Y_W-1:0];
    w_r <= wq[DIV5_SHIFT +: W_W];
  end

  // Pipeline advance, from the output back.
  assign adv3 = !out_v_r || out_ch.ready;
  assign adv2 = !s2_v_r || adv3;
  assign adv1 = !s1_v_r || adv2;
  assign in_ch.ready = adv1 && !freq_hold_r;
  assign in_acc   = in_ch.valid && adv1 && !freq_hold_r;
  assign tick_acc = in_acc && (in_ch.mode == MODE_TICK);

  // Phase accumulator.
  assign acc_nxt = acc_r + step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (tick_acc) begin
      acc_r <= acc_nxt;
    end
  end

  // Table banks. Table k+1 of a mixed band is always in the other bank from table k.
  assign load_ok = in_acc && (in_ch.mode == MODE_LOAD)
                   && (in_ch.table_select < SEL_W'(TABLE_COUNT))
                   && (32'(in_ch.table_index) < 32'(TABLE_SIZE));
  assign wr_addr = {in_ch.table_select[SEL_W-1:1], IDX_W'(in_ch.table_index)};
  assign rd_idx  = acc_nxt[PHASE_W-1 -: IDX_W];

  always_comb begin
    unique case (band_kind)
      BAND_MIX: even_slot = SLOT_W'((band_k + OCT_W'(1)) >> 1);
      BAND_TOP: even_slot = TOP_EVEN_SLOT;
      default:  even_slot = '0;
    endcase
  end

  assign even_rd_addr = {even_slot, rd_idx};
  assign odd_rd_addr  = {SLOT_W'(band_k >> 1), rd_idx};

  always_ff @(posedge clk) begin
    if (load_ok && !in_ch.table_select[0]) begin
      even_mem[wr_addr] <= in_ch.table_word;
    end
    if (tick_acc) begin
      even_rd_r <= even_mem[even_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok && in_ch.table_select[0]) begin
      odd_mem[wr_addr] <= in_ch.table_word;
    end
    if (tick_acc) begin
      odd_rd_r <= odd_mem[odd_rd_addr];
    end
  end

  // Crossfade as b + (a - b) * w; single-table bands pass the even word through, and the off band gives zero.
  always_comb begin
    w_sgn = $signed({1'b0, w_r});
    unique case (s1_kind_r)
      BAND_MIX: begin
        if (s1_swap_r) begin
          diff  = (WORD_W+1)'(odd_rd_r) - (WORD_W+1)'(even_rd_r);
          b_nxt = even_rd_r;
        end else begin
          diff  = (WORD_W+1)'(even_rd_r) - (WORD_W+1)'(odd_rd_r);
          b_nxt = odd_rd_r;
        end
      end
      BAND_OFF: begin
        diff  = '0;
        b_nxt = '0;
      end
      default: begin
        diff  = '0;
        b_nxt = even_rd_r;
      end
    endcase
    prod_nxt = (2*WORD_W+2)'(diff) * (2*WORD_W+2)'(w_sgn);
  end

  // Round half up and saturate.
  always_comb begin
    mix = ((2*WORD_W+3)'(b_r) <<< W_W) + (2*WORD_W+3)'(prod_r)
          + (2*WORD_W+3)'(32768);
    rnd = mix[2*WORD_W+2:W_W];
    if (rnd > (WORD_W+3)'(32767)) begin
      sat = 16'sh7FFF;
    end else if (rnd < -(WORD_W+3)'(32768)) begin
      sat = -16'sh8000;
    end else begin
      sat = rnd[WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (adv1) begin
        s1_v_r <= tick_acc;
      end
      if (adv2) begin
        s2_v_r <= s1_v_r;
      end
      if (adv3) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      s1_kind_r <= band_kind;
      s1_swap_r <= band_k[0];
    end
    if (adv2 && s1_v_r) begin
      prod_r <= prod_nxt;
      b_r    <= b_nxt;
    end
    if (adv3 && s2_v_r) begin
      out_r <= sat;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.sample_out = out_r;

`ifndef SYNTHESIS
  // A held table read must not be disturbed while the crossfade stage is stalled.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !adv2) |=> ($stable(even_rd_r) && $stable(odd_rd_r)))
    else $error("table read data changed during stall");

  // A load word leaves the phase alone.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.mode == MODE_LOAD) |=> $stable(acc_r))
    else $error("phase moved on a load word");

  // A tick advances the phase by exactly one step.
  assert property (@(posedge clk) disable iff (!rst_n)
    tick_acc |=> (acc_r == $past(acc_r + step_r)))
    else $error("phase advance mismatch");

  // Once the output is taken with no sample behind it, the output stage empties.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_ch.ready && !s2_v_r) |=> !out_v_r)
    else $error("output sample repeated");
`endif

endmodule
